[design/qse_pkg.sv]
// Shared types, constants and escape helpers for the quoted string escaper.
package qse_pkg;

    localparam int unsigned QSE_MAX_STRING_BYTES = 65535;
    localparam int unsigned QSE_COUNT_W          = 18;
    localparam int unsigned QSE_HARD_CAP         = 262142;
    localparam int unsigned QSE_FIFO_DEPTH       = 4;
    localparam int unsigned QSE_MAX_CHARS        = 6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_V  = 8'h76;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_HEX_A  = 8'h57; // 'a' - 10

    localparam logic [7:0] B_BS    = 8'h08;
    localparam logic [7:0] B_HT    = 8'h09;
    localparam logic [7:0] B_LF    = 8'h0a;
    localparam logic [7:0] B_VT    = 8'h0b;
    localparam logic [7:0] B_FF    = 8'h0c;
    localparam logic [7:0] B_CR    = 8'h0d;
    localparam logic [7:0] B_SPACE = 8'h20;
    localparam logic [7:0] B_DEL   = 8'h7f;
    localparam logic [7:0] B_HI_END = 8'ha0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_string;
        logic       last_of_string;
        logic       empty_string;
    } item_t;

    typedef struct packed {
        logic [7:0]             char_out;
        logic                   has_char;
        logic [QSE_COUNT_W-1:0] total_length;
        logic                   end_of_run;
    } result_t;

    // One queued request: the characters it expands to and how it ends.
    typedef struct packed {
        logic [QSE_MAX_CHARS-1:0][7:0] chars;
        logic [2:0]                    last_idx;
        logic                          no_char;
        logic                          ends;
        logic [QSE_COUNT_W-1:0]        total;
    } op_t;

    typedef struct packed {
        logic [3:0][7:0] seq;
        logic [2:0]      len;
    } esc_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? (CH_ZERO + {4'h0, n}) : (CH_HEX_A + {4'h0, n});
    endfunction

    function automatic esc_t escape_byte(input logic [7:0] b);
        esc_t e;
        e.seq    = '0;
        e.seq[0] = CH_BSLASH;
        e.len    = 3'd2;
        unique case (b)
            B_BS:      e.seq[1] = CH_LOW_B;
            B_HT:      e.seq[1] = CH_LOW_T;
            B_VT:      e.seq[1] = CH_LOW_V;
            B_LF:      e.seq[1] = CH_LOW_N;
            B_FF:      e.seq[1] = CH_LOW_F;
            B_CR:      e.seq[1] = CH_LOW_R;
            CH_QUOTE:  e.seq[1] = CH_QUOTE;
            CH_APOS:   e.seq[1] = CH_APOS;
            CH_BSLASH: e.seq[1] = CH_BSLASH;
            default:
            begin
                if (b < B_SPACE || (b >= B_DEL && b <= B_HI_END))
                begin
                    e.seq[1] = CH_LOW_X;
                    e.seq[2] = hex_digit(b[7:4]);
                    e.seq[3] = hex_digit(b[3:0]);
                    e.len    = 3'd4;
                end
                else
                begin
                    e.seq[0] = b;
                    e.len    = 3'd1;
                end
            end
        endcase
        return e;
    endfunction

endpackage

[design/qse_front.sv]
// Front end: takes input bytes, escapes them, keeps the running count, queues requests.
module qse_front #(
    parameter int unsigned MAX_STRING_BYTES = qse_pkg::QSE_MAX_STRING_BYTES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic           push,
    input  qse_pkg::item_t item,
    input  logic           fifo_full,
    output logic           wr_en,
    output qse_pkg::op_t   wr_op
);
    import qse_pkg::*;

    localparam longint unsigned LIM_RAW = 64'(MAX_STRING_BYTES) * 64'd4 + 64'd2;
    localparam logic [QSE_COUNT_W-1:0] COUNT_LIMIT =
        (LIM_RAW > 64'(QSE_HARD_CAP)) ? QSE_COUNT_W'(QSE_HARD_CAP) : QSE_COUNT_W'(LIM_RAW);

    logic                   measure_reg;
    logic [QSE_COUNT_W-1:0] count_reg, count_next;
    logic                   accept;
    op_t                    op;

    assign accept = push && !fifo_full;

    always_comb
    begin
        esc_t                   e;
        logic [2:0]             pos;
        logic [2:0]             add;
        logic [QSE_COUNT_W-1:0] base;
        logic [QSE_COUNT_W:0]   sum;
        logic [QSE_COUNT_W-1:0] sat;
        e          = escape_byte(item.data_byte);
        op         = '0;
        op.no_char = measure_reg;
        count_next = count_reg;
        pos        = 3'd0;
        add        = {2'b0, item.first_of_string} + e.len + {2'b0, item.last_of_string};
        base       = item.first_of_string ? '0 : count_reg;
        sum        = {1'b0, base} + (QSE_COUNT_W+1)'(add);
        sat        = (sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : sum[QSE_COUNT_W-1:0];
        if (item.empty_string)
        begin
            op.chars[0] = CH_QUOTE;
            op.chars[1] = CH_QUOTE;
            op.last_idx = measure_reg ? 3'd0 : 3'd1;
            op.ends     = 1'b1;
            op.total    = QSE_COUNT_W'(2);
            count_next  = '0;
        end
        else
        begin
            if (item.first_of_string)
            begin
                op.chars[0] = CH_QUOTE;
                pos         = 3'd1;
            end
            for (int i = 0; i < 4; i++)
            begin
                if (3'(i) < e.len)
                    op.chars[pos + 3'(i)] = e.seq[i];
            end
            pos = pos + e.len;
            if (item.last_of_string)
            begin
                op.chars[pos] = CH_QUOTE;
                op.ends       = 1'b1;
                op.total      = sat;
                count_next    = '0;
            end
            else
            begin
                count_next = sat;
            end
            op.last_idx = measure_reg ? 3'd0 : (add - 3'd1);
        end
    end

    // Measure mode queues only the end-of-string length request.
    assign wr_en = accept && (!measure_reg || item.last_of_string || item.empty_string);
    assign wr_op = op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measure_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                measure_reg <= cfg_wr_data;
            if (accept)
                count_reg <= count_next;
        end
    end

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_LIMIT)
        else $error("running count above limit");

    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.last_of_string || item.empty_string) |=> count_reg == '0)
        else $error("count not cleared at end of string");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !fifo_full)
        else $error("request queued into full fifo");

endmodule

[design/qse_fifo.sv]
// Short request queue between the front end and the back end.
module qse_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  qse_pkg::op_t wr_op,
    input  logic         rd_en,
    output qse_pkg::op_t rd_op,
    output logic         full,
    output logic         empty
);
    import qse_pkg::*;

    localparam int unsigned PTR_W = $clog2(QSE_FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(QSE_FIFO_DEPTH + 1);

    op_t              mem [QSE_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full  = (cnt_reg == CNT_W'(QSE_FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_op = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QSE_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QSE_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QSE_FIFO_DEPTH))
        else $error("fifo count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> wr_ptr_reg == rd_ptr_reg)
        else $error("fifo pointers disagree with count");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("fifo read while empty");

endmodule

[design/qse_back.sv]
// Back end: feeds requests to the result register one character per cycle while popped.
module qse_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fifo_empty,
    input  qse_pkg::op_t     head,
    output logic             rd_en,
    input  logic             pop,
    output logic             empty,
    output qse_pkg::result_t result
);
    import qse_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    result_t    result_reg, result_next;
    logic       load;
    logic       at_last;

    assign load    = !fifo_empty && (!valid_reg || pop);
    assign at_last = (idx_reg == head.last_idx);
    assign rd_en   = load && at_last;

    always_comb
    begin
        result_next.has_char     = !head.no_char;
        result_next.char_out     = head.no_char ? 8'h00 : head.chars[idx_reg];
        result_next.end_of_run   = at_last && head.ends;
        result_next.total_length = (at_last && head.ends) ? head.total : '0;
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = at_last ? 3'd0 : idx_reg + 3'd1;
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign empty  = !valid_reg;
    assign result = result_reg;

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !fifo_empty |-> idx_reg <= head.last_idx)
        else $error("character index past end of request");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_empty |-> idx_reg == 3'd0)
        else $error("character index left mid-request");

    a_total_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !result_reg.end_of_run |-> result_reg.total_length == '0)
        else $error("total shown on a non-final result");

endmodule

[design/quoted_string_escaper_core.sv]
// Top level of the quoted string escaper: front end, request fifo, back end.
//
//  channel   handshake            payload
//  input     push / full          item   (item_t)
//  result    empty / pop          result (result_t)
//  config    cfg_wr_en            cfg_wr_data (measure_only)
//
// One input byte is taken per cycle while the 4-entry request fifo has room.
// The back end emits one result per cycle while results are popped; a byte expands
// to up to 6 results, so escapes back up the fifo and raise full.
// An accepted request is written into the fifo, and its first result is then registered in the result register.
// Reset clears the running count, measure_only, the fifo and the result valid flag.
module quoted_string_escaper_core #(
    parameter int unsigned MAX_STRING_BYTES = qse_pkg::QSE_MAX_STRING_BYTES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             push,
    output logic             full,
    input  qse_pkg::item_t   item,
    input  logic             pop,
    output logic             empty,
    output qse_pkg::result_t result
);
    import qse_pkg::*;

    logic fifo_wr_en, fifo_rd_en, fifo_full, fifo_empty;
    op_t  fifo_wr_op, fifo_rd_op;

    qse_front #(
        .MAX_STRING_BYTES(MAX_STRING_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .push       (push),
        .item       (item),
        .fifo_full  (fifo_full),
        .wr_en      (fifo_wr_en),
        .wr_op      (fifo_wr_op)
    );

    qse_fifo u_fifo (
        .clk  (clk),
        .rst_n(rst_n),
        .wr_en(fifo_wr_en),
        .wr_op(fifo_wr_op),
        .rd_en(fifo_rd_en),
        .rd_op(fifo_rd_op),
        .full (fifo_full),
        .empty(fifo_empty)
    );

    qse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_empty(fifo_empty),
        .head      (fifo_rd_op),
        .rd_en     (fifo_rd_en),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    assign full = fifo_full;

endmodule
